// File: hw/rtl/rv32se_pkg.sv
// Shared types, constants and operation codes for the RV32 subset execute block.
package rv32se_pkg;

  // Machine word and register file geometry
  localparam int XLEN      = 32;
  localparam int REG_COUNT = 32;
  localparam int RA        = $clog2(REG_COUNT);
  localparam int IMM_W     = 12;
  localparam int OPC_W     = 3;

  // Data memory geometry: a word is selected by address bits from WORD_SHIFT upward.
  // MEM_WORDS must be a power of two so the index is a plain bit field.
  localparam int MEM_WORDS  = 1024;
  localparam int MEM_AW     = $clog2(MEM_WORDS);
  localparam int WORD_SHIFT = 3;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QA      = $clog2(Q_DEPTH);

  // Instruction opcodes as they arrive on the input channel
  typedef enum logic [OPC_W-1:0] {
    OP_ADD  = 3'd0,
    OP_ADDI = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_AND  = 3'd4,
    OP_OR   = 3'd5,
    OP_XOR  = 3'd6
  } opcode_t;

  // Function performed by the execute unit
  typedef enum logic [1:0] {
    K_ADD = 2'd0,
    K_AND = 2'd1,
    K_OR  = 2'd2,
    K_XOR = 2'd3
  } alu_kind_t;

  // Decoded instruction passed from front to back
  typedef struct packed {
    logic                    wr;       // register write that really happens
    logic [RA-1:0]           rd;       // destination, zero when no write
    logic [RA-1:0]           rs1;
    logic [RA-1:0]           rs2;
    logic signed [IMM_W-1:0] imm;
    alu_kind_t               kind;
    logic                    use_imm;  // second operand is the immediate
    logic                    load;
    logic                    store;
  } uop_t;

endpackage

// File: hw/rtl/rv32se_front.sv
// Front end: accept instructions, decode them and hand them to the queue.
module rv32se_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rv32se_pkg::OPC_W-1:0]         opcode,
  input  logic [rv32se_pkg::RA-1:0]            dest_index,
  input  logic [rv32se_pkg::RA-1:0]            src1_index,
  input  logic [rv32se_pkg::RA-1:0]            src2_index,
  input  logic signed [rv32se_pkg::IMM_W-1:0]  immediate,
  input  logic                                 hold,
  input  logic                                 q_full,
  output logic                                 push,
  output rv32se_pkg::uop_t                     push_uop
);

  logic             f_valid;
  rv32se_pkg::uop_t f_uop;
  rv32se_pkg::uop_t dec;

  // Classify the incoming instruction
  always_comb begin
    dec         = '0;
    dec.rs1     = src1_index;
    dec.rs2     = src2_index;
    dec.imm     = immediate;
    dec.kind    = rv32se_pkg::K_ADD;
    case (opcode)
      rv32se_pkg::OP_ADD: begin
        dec.wr = 1'b1;
      end
      rv32se_pkg::OP_ADDI: begin
        dec.wr      = 1'b1;
        dec.use_imm = 1'b1;
      end
      rv32se_pkg::OP_LW: begin
        dec.wr      = 1'b1;
        dec.use_imm = 1'b1;
        dec.load    = 1'b1;
      end
      rv32se_pkg::OP_SW: begin
        dec.use_imm = 1'b1;
        dec.store   = 1'b1;
      end
      rv32se_pkg::OP_AND: begin
        dec.wr   = 1'b1;
        dec.kind = rv32se_pkg::K_AND;
      end
      rv32se_pkg::OP_OR: begin
        dec.wr   = 1'b1;
        dec.kind = rv32se_pkg::K_OR;
      end
      rv32se_pkg::OP_XOR: begin
        dec.wr   = 1'b1;
        dec.kind = rv32se_pkg::K_XOR;
      end
      default: begin
        dec.wr = 1'b0;
      end
    endcase
    // Drop writes to register zero
    if (dest_index == '0) begin
      dec.wr = 1'b0;
    end
    dec.rd = dec.wr ? dest_index : '0;
  end

  // Hand the held instruction to the queue when there is room
  assign push     = f_valid && !q_full;
  assign push_uop = f_uop;
  assign in_ready = !hold && (!f_valid || !q_full);

  // Hold one decoded instruction
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_uop <= dec;
    end
  end

endmodule

// File: hw/rtl/rv32se_queue.sv
// Short instruction queue that decouples the front end from the back end.
module rv32se_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rv32se_pkg::uop_t push_uop,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output rv32se_pkg::uop_t head_uop
);

  rv32se_pkg::uop_t            q [rv32se_pkg::Q_DEPTH];
  logic [rv32se_pkg::QA-1:0]   wr_ptr;
  logic [rv32se_pkg::QA-1:0]   rd_ptr;
  logic [rv32se_pkg::QA:0]     count;

  assign full       = (count == (rv32se_pkg::QA+1)'(rv32se_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_uop   = q[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_uop;
    end
  end

endmodule

// File: hw/rtl/rv32se_back.sv
// Back end: register file, execute unit, data memory and result register.
module rv32se_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 head_valid,
  input  rv32se_pkg::uop_t                     head_uop,
  output logic                                 pop,
  output logic                                 clearing,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 reg_written,
  output logic [rv32se_pkg::RA-1:0]            written_index,
  output logic signed [rv32se_pkg::XLEN-1:0]   result_value,
  output logic                                 mem_written,
  output logic [rv32se_pkg::XLEN-1:0]          mem_address
);

  localparam int XLEN = rv32se_pkg::XLEN;
  localparam int RA   = rv32se_pkg::RA;
  localparam int MAW  = rv32se_pkg::MEM_AW;

  // Register file with reset-to-index handled by per-entry written bits
  logic [XLEN-1:0]                  rf [rv32se_pkg::REG_COUNT];
  logic [rv32se_pkg::REG_COUNT-1:0] rf_vld;

  // Data memory and its clearing sweep
  logic [XLEN-1:0] dmem [rv32se_pkg::MEM_WORDS];
  logic [MAW-1:0]  clr_idx;
  logic [XLEN-1:0] mem_rdata;

  // Execute stage
  logic             e1_valid;
  rv32se_pkg::uop_t e1_uop;
  logic [XLEN-1:0]  rs1_data;
  logic [XLEN-1:0]  rs2_data;

  // Memory stage
  logic            e2_valid;
  logic            e2_wr;
  logic [RA-1:0]   e2_rd;
  logic            e2_load;
  logic            e2_store;
  logic [XLEN-1:0] e2_val;
  logic [XLEN-1:0] e2_addr;
  logic [XLEN-1:0] e2_value;

  // Last register write, for operands read in the same cycle it landed
  logic            wb_en;
  logic [RA-1:0]   wb_rd;
  logic [XLEN-1:0] wb_val;

  logic            adv;
  logic [XLEN-1:0] opa;
  logic [XLEN-1:0] opb;
  logic [XLEN-1:0] imm32;
  logic [XLEN-1:0] addend;
  logic [XLEN-1:0] sum;
  logic [XLEN-1:0] alu;
  logic [XLEN-1:0] e1_val;
  logic [XLEN-1:0] e1_addr;
  logic [MAW-1:0]  mem_idx;
  logic            e1_store;
  logic            e1_load;

  // The whole back end moves when the result register can take a transaction
  assign adv = !out_valid || out_ready;
  assign pop = adv && head_valid && !clearing;

  assign e2_value = (e2_load && e2_wr) ? mem_rdata : e2_val;
  assign e1_store = e1_valid && e1_uop.store;
  assign e1_load  = e1_valid && e1_uop.load;

  // Forward operands from the memory stage and the last write
  always_comb begin
    if (e2_valid && e2_wr && (e2_rd == e1_uop.rs1)) begin
      opa = e2_value;
    end else if (wb_en && (wb_rd == e1_uop.rs1)) begin
      opa = wb_val;
    end else begin
      opa = rs1_data;
    end
    if (e2_valid && e2_wr && (e2_rd == e1_uop.rs2)) begin
      opb = e2_value;
    end else if (wb_en && (wb_rd == e1_uop.rs2)) begin
      opb = wb_val;
    end else begin
      opb = rs2_data;
    end
  end

  // Compute the result and effective address
  always_comb begin
    imm32  = {{(XLEN-rv32se_pkg::IMM_W){e1_uop.imm[rv32se_pkg::IMM_W-1]}}, e1_uop.imm};
    addend = e1_uop.use_imm ? imm32 : opb;
    sum    = opa + addend;
    case (e1_uop.kind)
      rv32se_pkg::K_ADD: alu = sum;
      rv32se_pkg::K_AND: alu = opa & opb;
      rv32se_pkg::K_OR:  alu = opa | opb;
      rv32se_pkg::K_XOR: alu = opa ^ opb;
      default:           alu = sum;
    endcase
    e1_val  = e1_uop.store ? opb : (e1_uop.wr ? alu : '0);
    e1_addr = (e1_uop.load || e1_uop.store) ? sum : '0;
    mem_idx = sum[rv32se_pkg::WORD_SHIFT +: MAW];
  end

  // Read operands on entry to execute; write back from the memory stage
  always_ff @(posedge clk) begin
    if (adv) begin
      rs1_data <= rf_vld[head_uop.rs1] ? rf[head_uop.rs1] : XLEN'(head_uop.rs1);
      rs2_data <= rf_vld[head_uop.rs2] ? rf[head_uop.rs2] : XLEN'(head_uop.rs2);
      if (e2_valid && e2_wr) begin
        rf[e2_rd] <= e2_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (adv && e2_valid && e2_wr) begin
      rf_vld[e2_rd] <= 1'b1;
    end
  end

  // Sweep the data memory to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == MAW'(rv32se_pkg::MEM_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Data memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (clearing) begin
      dmem[clr_idx] <= '0;
    end else if (adv && e1_store) begin
      dmem[mem_idx] <= opb;
    end
    if (adv && e1_load) begin
      mem_rdata <= dmem[mem_idx];
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid  <= 1'b0;
      e2_valid  <= 1'b0;
      out_valid <= 1'b0;
      wb_en     <= 1'b0;
    end else if (adv) begin
      e1_valid  <= pop;
      e2_valid  <= e1_valid;
      out_valid <= e2_valid;
      wb_en     <= e2_valid && e2_wr;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      e1_uop        <= head_uop;
      e2_wr         <= e1_uop.wr;
      e2_rd         <= e1_uop.rd;
      e2_load       <= e1_uop.load;
      e2_store      <= e1_uop.store;
      e2_val        <= e1_val;
      e2_addr       <= e1_addr;
      wb_rd         <= e2_rd;
      wb_val        <= e2_value;
      reg_written   <= e2_wr;
      written_index <= e2_rd;
      result_value  <= $signed(e2_value);
      mem_written   <= e2_store;
      mem_address   <= e2_addr;
    end
  end

endmodule

// File: hw/rtl/rv32_subset_execute.sv
// Top level of the RV32 subset execute block: front end, queue and back end.
//
// Executes ADD, ADDI, AND, OR, XOR, LW and SW, one instruction per transaction,
// on a 32 x 32-bit register file (entry i holds i after reset, register zero
// stays zero) and a MEM_WORDS x 32-bit data memory indexed by address bits
// above bit 2. Sustained rate is one instruction per cycle while out_ready
// stays high, including dependent instructions and a load followed by its
// use: operands are forwarded from the memory stage and from the last register
// write, and the data memory's single port serves one load or store per cycle.
// A result passes through the front-end register, the queue, the execute and
// memory stages and the result register. After reset the data memory is swept
// to zero, during which in_ready stays low. Instructions are taken while a
// finished result waits on the output; a short queue lets the front end keep
// accepting while the back end is stalled.
module rv32_subset_execute (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rv32se_pkg::OPC_W-1:0]         opcode,
  input  logic [rv32se_pkg::RA-1:0]            dest_index,
  input  logic [rv32se_pkg::RA-1:0]            src1_index,
  input  logic [rv32se_pkg::RA-1:0]            src2_index,
  input  logic signed [rv32se_pkg::IMM_W-1:0]  immediate,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 reg_written,
  output logic [rv32se_pkg::RA-1:0]            written_index,
  output logic signed [rv32se_pkg::XLEN-1:0]   result_value,
  output logic                                 mem_written,
  output logic [rv32se_pkg::XLEN-1:0]          mem_address
);

  logic             push;
  logic             q_full;
  logic             pop;
  logic             head_valid;
  logic             clearing;
  rv32se_pkg::uop_t push_uop;
  rv32se_pkg::uop_t head_uop;

  // Accept and decode
  rv32se_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .dest_index (dest_index),
    .src1_index (src1_index),
    .src2_index (src2_index),
    .immediate  (immediate),
    .hold       (clearing),
    .q_full     (q_full),
    .push       (push),
    .push_uop   (push_uop)
  );

  // Decouple front and back
  rv32se_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_uop   (push_uop),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_uop   (head_uop)
  );

  // Execute and deliver results
  rv32se_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_uop      (head_uop),
    .pop           (pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .reg_written   (reg_written),
    .written_index (written_index),
    .result_value  (result_value),
    .mem_written   (mem_written),
    .mem_address   (mem_address)
  );

endmodule

// File: bench/tb_rv32_subset_execute.sv
// Self-checking testbench for the RV32 subset execute block: directed table, then random programs.
`timescale 1ns / 100ps

module tb_rv32_subset_execute;
  import rv32se_pkg::*;

  // Opcode value that the block treats as a no-op
  localparam logic [OPC_W-1:0] OP_NONE = 3'd7;

  typedef struct packed {
    logic [OPC_W-1:0]  op;
    logic [RA-1:0]     rd;
    logic [RA-1:0]     rs1;
    logic [RA-1:0]     rs2;
    logic [IMM_W-1:0]  imm;
  } instr_t;

  typedef struct packed {
    logic              rw;
    logic [RA-1:0]     idx;
    logic [XLEN-1:0]   val;
    logic              mw;
    logic [XLEN-1:0]   addr;
  } result_t;

  // One row of the directed table; typed rows carry a hand-written result
  typedef struct packed {
    instr_t            ins;
    logic              typed;
    result_t           exp;
  } row_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [OPC_W-1:0]         opcode;
  logic [RA-1:0]            dest_index;
  logic [RA-1:0]            src1_index;
  logic [RA-1:0]            src2_index;
  logic signed [IMM_W-1:0]  immediate;
  logic                     out_valid;
  logic                     out_ready;
  logic                     reg_written;
  logic [RA-1:0]            written_index;
  logic signed [XLEN-1:0]   result_value;
  logic                     mem_written;
  logic [XLEN-1:0]          mem_address;

  // Architectural state mirrored by the predictor
  logic [XLEN-1:0]  reg_model [REG_COUNT];
  logic [XLEN-1:0]  mem_model [MEM_WORDS];

  result_t   expected_q [$];
  instr_t    pending_instr [$];
  row_t      directed_rows [$];

  // Side information that travels with the instruction on the input port
  logic      row_typed;
  result_t   row_expect;

  int unsigned  fail_count;
  int unsigned  results_seen;
  int unsigned  random_sent;
  bit           paused_once;

  result_t   got_r;
  result_t   want_r;
  result_t   pred_r;
  instr_t    acc_ins;

  rv32_subset_execute DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .dest_index    (dest_index),
    .src1_index    (src1_index),
    .src2_index    (src2_index),
    .immediate     (immediate),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .reg_written   (reg_written),
    .written_index (written_index),
    .result_value  (result_value),
    .mem_written   (mem_written),
    .mem_address   (mem_address)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("rv32_subset_execute: mismatch");
    $finish;
  end

  // Execute one instruction on the mirrored state and return its result
  function automatic result_t exec_predict(input instr_t ins);
    logic [XLEN-1:0]    a;
    logic [XLEN-1:0]    b;
    logic [XLEN-1:0]    ea;
    logic [XLEN-1:0]    val;
    logic [XLEN-1:0]    addr;
    logic [MEM_AW-1:0]  widx;
    logic               wr;
    logic               wm;
    result_t            r;
    a    = reg_model[ins.rs1];
    b    = reg_model[ins.rs2];
    ea   = a + {{(XLEN-IMM_W){ins.imm[IMM_W-1]}}, ins.imm};
    widx = MEM_AW'((ea >> WORD_SHIFT) % MEM_WORDS);
    val  = '0;
    addr = '0;
    wr   = 1'b0;
    wm   = 1'b0;
    case (ins.op)
      OP_ADD: begin
        val = a + b;
        wr  = 1'b1;
      end
      OP_ADDI: begin
        val = ea;
        wr  = 1'b1;
      end
      OP_AND: begin
        val = a & b;
        wr  = 1'b1;
      end
      OP_OR: begin
        val = a | b;
        wr  = 1'b1;
      end
      OP_XOR: begin
        val = a ^ b;
        wr  = 1'b1;
      end
      OP_LW: begin
        addr = ea;
        val  = mem_model[widx];
        wr   = 1'b1;
      end
      OP_SW: begin
        addr            = ea;
        val             = b;
        mem_model[widx] = b;
        wm              = 1'b1;
      end
      default: ;
    endcase
    // Drop writes to register zero
    if (wr && ins.rd == '0) begin
      wr  = 1'b0;
      val = '0;
    end
    if (wr) reg_model[ins.rd] = val;
    r.rw   = wr;
    r.idx  = wr ? ins.rd : '0;
    r.val  = val;
    r.mw   = wm;
    r.addr = addr;
    return r;
  endfunction

  // Register number biased toward a small pool so that hazards are frequent
  function automatic logic [RA-1:0] pick_reg();
    if ($urandom_range(0, 9) < 7) return RA'($urandom_range(0, 7));
    return RA'($urandom_range(0, REG_COUNT - 1));
  endfunction

  function automatic instr_t rand_instr();
    instr_t       t;
    int unsigned  r;
    r     = $urandom_range(0, 99);
    t.op  = (r < 4) ? OP_NONE : OPC_W'($urandom_range(0, 6));
    t.rd  = pick_reg();
    t.rs1 = pick_reg();
    t.rs2 = pick_reg();
    case ($urandom_range(0, 9))
      0:       t.imm = 12'h800;
      1:       t.imm = 12'h7FF;
      2:       t.imm = 12'hFFF;
      3:       t.imm = 12'h000;
      default: t.imm = IMM_W'($urandom_range(0, 4095));
    endcase
    return t;
  endfunction

  // Queue a short program fragment: lone op, store/load pair, chain or noise
  task automatic gen_burst();
    instr_t       a;
    instr_t       b;
    int unsigned  kind;
    int unsigned  n;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      pending_instr.push_back(rand_instr());
    end else if (kind < 75) begin
      a    = rand_instr();
      a.op = OP_SW;
      pending_instr.push_back(a);
      n = $urandom_range(0, 2);
      repeat (n) pending_instr.push_back(rand_instr());
      // load back through the same base register and word offset, any byte offset within the word
      b     = rand_instr();
      b.op  = OP_LW;
      b.rs1 = a.rs1;
      b.imm = {a.imm[IMM_W-1:WORD_SHIFT], b.imm[WORD_SHIFT-1:0]};
      pending_instr.push_back(b);
    end else if (kind < 95) begin
      a    = rand_instr();
      a.op = OP_ADDI;
      pending_instr.push_back(a);
      b = rand_instr();
      if (b.op == OP_NONE) b.op = OP_ADD;
      if ($urandom_range(0, 1)) b.rs1 = a.rd;
      else b.rs2 = a.rd;
      pending_instr.push_back(b);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        a    = rand_instr();
        a.op = OP_NONE;
        pending_instr.push_back(a);
      end
    end
  endtask

  // Gap length: mostly short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(input logic [OPC_W-1:0] op, input int rd,
                         input int rs1, input int rs2,
                         input logic [IMM_W-1:0] imm, input int typed,
                         input int rw, input int idx,
                         input logic [XLEN-1:0] val, input int mw,
                         input logic [XLEN-1:0] addr);
    row_t row;
    row.ins.op   = op;
    row.ins.rd   = RA'(rd);
    row.ins.rs1  = RA'(rs1);
    row.ins.rs2  = RA'(rs2);
    row.ins.imm  = imm;
    row.typed    = typed[0];
    row.exp.rw   = rw[0];
    row.exp.idx  = RA'(idx);
    row.exp.val  = val;
    row.exp.mw   = mw[0];
    row.exp.addr = addr;
    directed_rows.push_back(row);
  endtask

  // Offer one transaction and hold it until accepted; returns at a falling edge
  task automatic send_instr(input instr_t ins, input logic typed, input result_t expv);
    opcode     = ins.op;
    dest_index = ins.rd;
    src1_index = ins.rs1;
    src2_index = ins.rs2;
    immediate  = ins.imm;
    row_typed  = typed;
    row_expect = expv;
    in_valid   = 1'b1;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    @(negedge clk);
  endtask

  task automatic idle_gap(input int unsigned n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Check finished transactions and predict accepted ones
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        got_r.rw   = reg_written;
        got_r.idx  = written_index;
        got_r.val  = result_value;
        got_r.mw   = mem_written;
        got_r.addr = mem_address;
        if (expected_q.size() == 0) begin
          $error("result with no instruction outstanding");
          fail_count++;
        end else begin
          want_r = expected_q.pop_front();
          if (got_r.rw !== want_r.rw) begin
            $error("reg_written: expected %0d, got %0d", want_r.rw, got_r.rw);
            fail_count++;
          end
          if (got_r.idx !== want_r.idx) begin
            $error("written_index: expected %0d, got %0d", want_r.idx, got_r.idx);
            fail_count++;
          end
          if (got_r.val !== want_r.val) begin
            $error("result_value: expected %h, got %h", want_r.val, got_r.val);
            fail_count++;
          end
          if (got_r.mw !== want_r.mw) begin
            $error("mem_written: expected %0d, got %0d", want_r.mw, got_r.mw);
            fail_count++;
          end
          if (got_r.addr !== want_r.addr) begin
            $error("mem_address: expected %h, got %h", want_r.addr, got_r.addr);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        acc_ins.op  = opcode;
        acc_ins.rd  = dest_index;
        acc_ins.rs1 = src1_index;
        acc_ins.rs2 = src2_index;
        acc_ins.imm = immediate;
        pred_r = exec_predict(acc_ins);
        expected_q.push_back(row_typed ? row_expect : pred_r);
      end
    end
  end

  // Receiver: random back-pressure, quiet stretches and one long hold-off
  initial begin
    int unsigned  gap_left;
    int unsigned  rx_cycle;
    bit           held;
    gap_left  = 0;
    rx_cycle  = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (!held && results_seen >= 150) begin
        // stall the output long enough to back up into the input
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
      end else if (gap_left > 0) begin
        out_ready = 1'b0;
        gap_left--;
      end else begin
        out_ready = 1'b1;
        if (((rx_cycle / 200) % 3) != 0 && $urandom_range(0, 3) == 0) gap_left = gap_len();
      end
    end
  end

  // Sender: reset, directed table, random programs, drain
  initial begin
    instr_t       ins;
    int unsigned  gap;
    in_valid     = 1'b0;
    opcode       = '0;
    dest_index   = '0;
    src1_index   = '0;
    src2_index   = '0;
    immediate    = '0;
    row_typed    = 1'b0;
    row_expect   = '0;
    fail_count   = 0;
    results_seen = 0;
    random_sent  = 0;
    paused_once  = 1'b0;
    for (int i = 0; i < REG_COUNT; i++) reg_model[i] = i;
    for (int i = 0; i < MEM_WORDS; i++) mem_model[i] = '0;

    //       op       rd  rs1 rs2 imm      typed rw idx val             mw addr
    add_row(OP_ADD,   1,  2,  3,  12'h000, 1,    1, 1,  32'h0000_0005, 0, 32'h0);
    // write to register zero is dropped
    add_row(OP_ADD,   0,  31, 31, 12'h000, 1,    0, 0,  32'h0,         0, 32'h0);
    add_row(OP_ADDI,  5,  0,  0,  12'h800, 1,    1, 5,  32'hFFFF_F800, 0, 32'h0);
    add_row(OP_ADDI,  6,  0,  0,  12'h7FF, 1,    1, 6,  32'h0000_07FF, 0, 32'h0);
    add_row(OP_ADDI,  7,  0,  0,  12'hFFF, 1,    1, 7,  32'hFFFF_FFFF, 0, 32'h0);
    add_row(OP_AND,   8,  7,  31, 12'h000, 0,    0, 0,  32'h0,         0, 32'h0);
    add_row(OP_OR,    9,  5,  6,  12'h000, 0,    0, 0,  32'h0,         0, 32'h0);
    add_row(OP_XOR,   10, 7,  6,  12'h000, 0,    0, 0,  32'h0,         0, 32'h0);
    // effective address wraps past the top to zero
    add_row(OP_SW,    0,  7,  31, 12'h001, 0,    0, 0,  32'h0,         0, 32'h0);
    add_row(OP_LW,    11, 0,  0,  12'h000, 0,    0, 0,  32'h0,         0, 32'h0);
    // load into register zero still reports its address
    add_row(OP_LW,    0,  0,  0,  12'h004, 1,    0, 0,  32'h0,         0, 32'h4);
    // unused opcode does nothing
    add_row(OP_NONE,  31, 31, 31, 12'hFFF, 1,    0, 0,  32'h0,         0, 32'h0);
    add_row(OP_SW,    31, 6,  7,  12'h7FF, 0,    0, 0,  32'h0,         0, 32'h0);
    add_row(OP_LW,    12, 6,  0,  12'h7FF, 0,    0, 0,  32'h0,         0, 32'h0);
    add_row(OP_LW,    13, 20, 0,  12'h064, 1,    1, 13, 32'h0,         0, 32'h78);
    add_row(OP_ADD,   14, 12, 12, 12'h000, 0,    0, 0,  32'h0,         0, 32'h0);
    add_row(OP_ADD,   31, 7,  7,  12'h000, 0,    0, 0,  32'h0,         0, 32'h0);
    add_row(OP_SW,    31, 0,  31, 12'hFF8, 0,    0, 0,  32'h0,         0, 32'h0);
    add_row(OP_LW,    15, 0,  0,  12'hFF8, 0,    0, 0,  32'h0,         0, 32'h0);
    add_row(OP_XOR,   16, 16, 16, 12'h000, 0,    0, 0,  32'h0,         0, 32'h0);
    add_row(OP_AND,   0,  7,  7,  12'h000, 1,    0, 0,  32'h0,         0, 32'h0);
    add_row(OP_OR,    17, 0,  0,  12'h000, 1,    1, 17, 32'h0,         0, 32'h0);

    // Hold reset, then release it
    rst = 1'b1;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      gap = gap_len();
      if (gap > 0) idle_gap(gap);
      send_instr(directed_rows[i].ins, directed_rows[i].typed, directed_rows[i].exp);
    end

    // Random programs
    while (random_sent < 750) begin
      if (pending_instr.size() == 0) gen_burst();
      ins = pending_instr.pop_front();
      if (!paused_once && random_sent >= 350) begin
        // pause until every outstanding transaction has completed
        paused_once = 1'b1;
        in_valid    = 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      gap = (((random_sent / 64) % 3) == 0) ? 0 : gap_len();
      if (gap > 0) idle_gap(gap);
      send_instr(ins, 1'b0, '0);
      if (ins.op != OP_NONE) random_sent++;
    end

    // Drain and let the pipeline settle
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("rv32_subset_execute: match");
    end else begin
      $display("rv32_subset_execute: mismatch");
    end
    $finish;
  end

endmodule

// File: rv32_subset_execute.f
hw/rtl/rv32se_pkg.sv
hw/rtl/rv32se_front.sv
hw/rtl/rv32se_queue.sv
hw/rtl/rv32se_back.sv
hw/rtl/rv32_subset_execute.sv
bench/tb_rv32_subset_execute.sv
